>>> sv/scan_dedup_log_engine_unit_macros.svh
// Assertion macros for the scan dedup log engine.
`ifndef SCAN_DEDUP_LOG_ENGINE_UNIT_MACROS_SVH
`define SCAN_DEDUP_LOG_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define SDL_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under active-low reset.
`define SDL_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdl_pkg.sv
// Shared constants and types of the scan dedup log engine.
`timescale 1ns / 1ps

package sdl_pkg;

    localparam int SCAN_MAX  = 16;
    localparam int LOG_SLOTS = 64;

    localparam int IDX_W   = $clog2(SCAN_MAX);
    localparam int ELEM_W  = $clog2(SCAN_MAX + 2);
    localparam int COUNT_W = 5;
    localparam int USED_W  = 7;
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 48;
    localparam int RAM_DEPTH = 2 * SCAN_MAX;
    localparam int RAM_AW    = IDX_W + 1;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    localparam logic STATUS_STORED   = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

>>> sv/scan_dedup_log_engine_unit.sv
// Top level of the scan dedup log engine.
`timescale 1ns / 1ps
`include "scan_dedup_log_engine_unit_macros.svh"

// Scan dedup and log bookkeeping. Each input word carries one access point
// identifier of a radio scan; tlast marks the final word, and tuser (op) on
// that word picks check (0) or record (1). A word is accepted and its identifier
// staged, then each stored identifier goes in turn through the single shared
// 48-bit comparator fed from the identifier RAM (registered read, so the last
// compare drains after the reads end), and then the word finishes. A final
// or empty word also waits in finish while the result register is still full.
// An empty scan (scan_count 0) skips the compare. s_tready is low while a word is
// being worked on. The identifier RAM holds two banks of SCAN_MAX entries:
// words are staged into the inactive bank, and a successful record just flips
// the bank, so no copy pass is needed. An empty word and a final word give one
// result word on m_*; other words give none. The result register lets the
// next scan word be accepted while a result is still waiting. The user writes
// min_age via cfg_* (always ready) only while idle; the block does not check.
module scan_dedup_log_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // time_ms[31:0], bssid[79:32], scan_count[84:80], zero pad[87:85]
    input  logic [sdl_pkg::IN_DATA_W-1:0] s_tdata,
    // op[0]
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // record_wanted[0], status[1], used_entries[8:2], write_slot[14:9], pad[15]
    output logic [sdl_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration: min_age
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdl_pkg::TIME_W-1:0]    cfg_data
);

    sdl_pkg::state_t state_reg, state_next;

    // latched word
    logic                        op_reg, op_next;
    logic [sdl_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [sdl_pkg::ID_W-1:0]    id_reg, id_next;
    logic [sdl_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        last_reg, last_next;
    logic                        empty_reg, empty_next;

    // bookkeeping state
    logic [sdl_pkg::TIME_W-1:0]   min_age_reg;
    logic [sdl_pkg::USED_W-1:0]   used_count_reg, used_count_next;
    logic [sdl_pkg::SLOT_W-1:0]   next_slot_reg, next_slot_next;
    logic [sdl_pkg::TIME_W-1:0]   stored_time_reg, stored_time_next;
    logic [sdl_pkg::COUNT_W-1:0]  stored_count_reg, stored_count_next;
    logic [sdl_pkg::SCAN_MAX-1:0] found_mask_reg, found_mask_next;
    logic [sdl_pkg::ELEM_W-1:0]   elem_index_reg, elem_index_next;
    logic                         bank_reg, bank_next;

    // compare sequencer
    logic [sdl_pkg::COUNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                        pend_reg, pend_next;
    logic [sdl_pkg::IDX_W-1:0]   pend_idx_reg, pend_idx_next;

    // result register
    logic                            m_valid_reg, m_valid_next;
    logic [sdl_pkg::OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    // RAM
    logic                        ram_we;
    logic [sdl_pkg::RAM_AW-1:0]  ram_waddr, ram_raddr;
    logic [sdl_pkg::ID_W-1:0]    ram_rdata;

    // input fields
    logic [sdl_pkg::TIME_W-1:0]  in_time;
    logic [sdl_pkg::ID_W-1:0]    in_id;
    logic [sdl_pkg::COUNT_W-1:0] in_cnt;
    logic                        in_fire;

    // finish decode
    logic                         out_free;
    logic                         res_needed;
    logic                         good;
    logic                         want;
    logic                         rec_ok;
    logic [sdl_pkg::TIME_W-1:0]   age;
    logic [sdl_pkg::SCAN_MAX-1:0] full_mask;
    logic                         rd_en;
    logic                         fin_fire;

    assign in_time = s_tdata[31:0];
    assign in_id   = s_tdata[79:32];
    assign in_cnt  = s_tdata[84:80];

    assign s_tready  = (state_reg == sdl_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // staging write to the inactive bank
    assign ram_we    = in_fire && (in_cnt != '0)
                       && (elem_index_reg < sdl_pkg::ELEM_W'(sdl_pkg::SCAN_MAX));
    assign ram_waddr = {~bank_reg, elem_index_reg[sdl_pkg::IDX_W-1:0]};
    assign ram_raddr = {bank_reg, rd_idx_reg[sdl_pkg::IDX_W-1:0]};

    sdl_ram #(
        .WIDTH(sdl_pkg::ID_W),
        .DEPTH(sdl_pkg::RAM_DEPTH)
    ) u_ids (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_id),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // stored entries below stored_count must all be seen
    always_comb
    begin
        for (int i = 0; i < sdl_pkg::SCAN_MAX; i++)
        begin
            full_mask[i] = (sdl_pkg::COUNT_W'(i) < stored_count_reg);
        end
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign res_needed = empty_reg || last_reg;
    assign rd_en      = (rd_idx_reg < stored_count_reg);
    assign age        = time_reg - stored_time_reg;
    assign good       = (elem_index_reg == sdl_pkg::ELEM_W'(cnt_reg))
                        && (cnt_reg <= sdl_pkg::COUNT_W'(sdl_pkg::SCAN_MAX));
    assign want       = !good || (used_count_reg == '0) || (age >= min_age_reg)
                        || (stored_count_reg != cnt_reg)
                        || ((found_mask_reg & full_mask) != full_mask);
    assign rec_ok     = !empty_reg && good;
    assign fin_fire   = (state_reg == sdl_pkg::ST_FIN) && (!res_needed || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_age_reg      <= '0;
            used_count_reg   <= '0;
            next_slot_reg    <= '0;
            stored_time_reg  <= '0;
            stored_count_reg <= '0;
            found_mask_reg   <= '0;
            elem_index_reg   <= '0;
            bank_reg         <= 1'b0;
            rd_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_age_reg <= cfg_data;
            end
            used_count_reg   <= used_count_next;
            next_slot_reg    <= next_slot_next;
            stored_time_reg  <= stored_time_next;
            stored_count_reg <= stored_count_next;
            found_mask_reg   <= found_mask_next;
            elem_index_reg   <= elem_index_next;
            bank_reg         <= bank_next;
            rd_idx_reg       <= rd_idx_next;
            pend_reg         <= pend_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        time_reg     <= time_next;
        id_reg       <= id_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        pend_idx_reg <= pend_idx_next;
        m_data_reg   <= m_data_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        time_next         = time_reg;
        id_next           = id_reg;
        cnt_next          = cnt_reg;
        last_next         = last_reg;
        empty_next        = empty_reg;
        used_count_next   = used_count_reg;
        next_slot_next    = next_slot_reg;
        stored_time_next  = stored_time_reg;
        stored_count_next = stored_count_reg;
        found_mask_next   = found_mask_reg;
        elem_index_next   = elem_index_reg;
        bank_next         = bank_reg;
        rd_idx_next       = rd_idx_reg;
        pend_next         = 1'b0;
        pend_idx_next     = pend_idx_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;

        unique case (state_reg)
            sdl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_tuser;
                    time_next   = in_time;
                    id_next     = in_id;
                    cnt_next    = in_cnt;
                    last_next   = s_tlast;
                    empty_next  = (in_cnt == '0);
                    rd_idx_next = '0;
                    if (in_cnt == '0)
                    begin
                        state_next = sdl_pkg::ST_FIN;
                    end
                    else
                    begin
                        if (elem_index_reg <= sdl_pkg::ELEM_W'(sdl_pkg::SCAN_MAX))
                        begin
                            elem_index_next = elem_index_reg + 1'b1;
                        end
                        state_next = sdl_pkg::ST_SCAN;
                    end
                end
            end

            sdl_pkg::ST_SCAN:
            begin
                // read one stored id per cycle, compare it in the next cycle
                if (rd_en)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[sdl_pkg::IDX_W-1:0];
                end
                if (pend_reg && (ram_rdata == id_reg))
                begin
                    found_mask_next[pend_idx_reg] = 1'b1;
                end
                if (!rd_en)
                begin
                    state_next = sdl_pkg::ST_FIN;
                end
            end

            sdl_pkg::ST_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = sdl_pkg::ST_IDLE;
                    if (res_needed)
                    begin
                        elem_index_next = '0;
                        found_mask_next = '0;
                        m_valid_next    = 1'b1;
                        if (op_reg == sdl_pkg::OP_CHECK)
                        begin
                            m_data_next = {1'b0, next_slot_reg, used_count_reg,
                                           sdl_pkg::STATUS_STORED, want && !empty_reg};
                        end
                        else if (rec_ok)
                        begin
                            bank_next         = ~bank_reg;
                            stored_count_next = cnt_reg;
                            stored_time_next  = time_reg;
                            if (next_slot_reg == sdl_pkg::SLOT_W'(sdl_pkg::LOG_SLOTS - 1))
                            begin
                                next_slot_next = '0;
                            end
                            else
                            begin
                                next_slot_next = next_slot_reg + 1'b1;
                            end
                            if (used_count_reg < sdl_pkg::USED_W'(sdl_pkg::LOG_SLOTS))
                            begin
                                used_count_next = used_count_reg + 1'b1;
                            end
                            m_data_next = {1'b0, next_slot_next, used_count_next,
                                           sdl_pkg::STATUS_STORED, 1'b0};
                        end
                        else
                        begin
                            m_data_next = {1'b0, next_slot_reg, used_count_reg,
                                           sdl_pkg::STATUS_REJECTED, 1'b0};
                        end
                    end
                end
            end

            default:
            begin
                state_next = sdl_pkg::ST_IDLE;
            end
        endcase
    end

    // bookkeeping bounds
    `SDL_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1,
        used_count_reg <= sdl_pkg::USED_W'(sdl_pkg::LOG_SLOTS), "used count overflow")
    `SDL_ASSERT_NOW(a_elem_bound, clk, rst_n, 1'b1,
        elem_index_reg <= sdl_pkg::ELEM_W'(sdl_pkg::SCAN_MAX + 1), "elem index overflow")
    // a successful record flips the active bank
    `SDL_ASSERT_NEXT(a_bank_flip, clk, rst_n,
        fin_fire && res_needed && (op_reg == sdl_pkg::OP_RECORD) && rec_ok,
        bank_reg != $past(bank_reg), "bank not flipped on record")
    // a result is only loaded when the result register is free
    `SDL_ASSERT_NOW(a_no_overrun, clk, rst_n, fin_fire && res_needed,
        !m_valid_reg || m_tready, "result register overrun")

endmodule

>>> sv/sdl_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module sdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sim/tb_scan_dedup_log_engine_unit.sv
// Self-checking testbench for the scan dedup log engine: scan streams in, check/record replies out.
`timescale 1ns / 1ps

module tb_scan_dedup_log_engine_unit;

    import sdl_pkg::*;

    // Result word layout, MSB first, so a cast of m_tdata[14:0] lines up.
    typedef struct packed {
        logic [SLOT_W-1:0] write_slot;
        logic [USED_W-1:0] used_entries;
        logic              status;
        logic              record_wanted;
    } log_reply_t;

    typedef logic [ID_W-1:0] id_list_t[$];

    // Tracks the log bookkeeping and the dedup decision for every accepted
    // scan word and holds the replies still owed by the block.
    class dedup_log_model;
        bit [TIME_W-1:0]   age_floor;
        bit [USED_W-1:0]   used;
        bit [SLOT_W-1:0]   slot;
        bit [TIME_W-1:0]   kept_time;
        bit [COUNT_W-1:0]  kept_count;
        bit [ID_W-1:0]     kept_ids[SCAN_MAX];
        bit [ID_W-1:0]     staging[SCAN_MAX];
        bit [SCAN_MAX-1:0] hit_mask;
        int                words_in_scan;
        log_reply_t        owed_replies[$];
        int                errors;

        function log_reply_t make_reply(logic want, logic status);
            log_reply_t r;
            r.record_wanted = want;
            r.status        = status;
            r.used_entries  = used;
            r.write_slot    = slot;
            return r;
        endfunction

        function void absorb_word(logic op, logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                                  logic [COUNT_W-1:0] cnt, logic last);
            logic              good;
            logic              want;
            logic [31:0]       full;
            logic [TIME_W-1:0] age;
            logic [SCAN_MAX-1:0] seen;
            if (cnt == 0)
            begin
                // empty scan: stands alone, drops any partial scan
                words_in_scan = 0;
                hit_mask = '0;
                owed_replies.push_back(make_reply(1'b0,
                    op == OP_RECORD ? STATUS_REJECTED : STATUS_STORED));
            end
            else
            begin
                if (words_in_scan < SCAN_MAX)
                    staging[words_in_scan] = id;
                for (int j = 0; j < kept_count; j++)
                    if (kept_ids[j] == id)
                        hit_mask[j] = 1'b1;
                if (words_in_scan <= SCAN_MAX)
                    words_in_scan++;
                if (last)
                begin
                    good = (words_in_scan == cnt) && (cnt <= SCAN_MAX);
                    seen = hit_mask;
                    words_in_scan = 0;
                    hit_mask = '0;
                    if (op == OP_CHECK)
                    begin
                        full = (32'd1 << kept_count) - 32'd1;
                        age  = t - kept_time;
                        want = !good || used == 0 || age >= age_floor || kept_count != cnt
                            || (seen & full[SCAN_MAX-1:0]) != full[SCAN_MAX-1:0];
                        owed_replies.push_back(make_reply(want, STATUS_STORED));
                    end
                    else if (!good)
                    begin
                        owed_replies.push_back(make_reply(1'b0, STATUS_REJECTED));
                    end
                    else
                    begin
                        for (int j = 0; j < cnt; j++)
                            kept_ids[j] = staging[j];
                        kept_count = cnt;
                        kept_time  = t;
                        slot = SLOT_W'((int'(slot) + 1) % LOG_SLOTS);
                        if (used < LOG_SLOTS)
                            used++;
                        owed_replies.push_back(make_reply(1'b0, STATUS_STORED));
                    end
                end
            end
        endfunction

        function void compare_field(string field, int want_v, int got_v);
            if (want_v != got_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_reply(log_reply_t got);
            log_reply_t due;
            if (owed_replies.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                due = owed_replies.pop_front();
                compare_field("record_wanted", due.record_wanted, got.record_wanted);
                compare_field("status", due.status, got.status);
                compare_field("used_entries", due.used_entries, got.used_entries);
                compare_field("write_slot", due.write_slot, got.write_slot);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TIME_W-1:0]      cfg_data = '0;

    dedup_log_model dedup = new();

    int words_sent   = 0;
    int replies_seen = 0;
    bit quiet        = 1'b0;   // end of run: no idling on either side
    bit src_calm     = 1'b0;   // sender stretch without gaps
    bit dst_calm     = 1'b0;   // receiver stretch without stalls
    bit held         = 1'b0;   // long receiver hold-off done

    scan_dedup_log_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Outputs are sampled at the falling edge: a word seen with valid and
    // ready high here is taken at the next rising edge, nothing moves between.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            dedup.check_reply(log_reply_t'(m_tdata[14:0]));
        end
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off
    // so the result register backs up and s_tready drops with words waiting.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && replies_seen >= 40)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!quiet && !dst_calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            if (!quiet && $urandom_range(0, 60) == 0)
                dst_calm = !dst_calm;
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [ID_W-1:0] random_id();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int pick_size();
        return ($urandom_range(0, 9) == 0) ? SCAN_MAX : $urandom_range(1, SCAN_MAX);
    endfunction

    // Check time placed around the age threshold, wrapping included.
    function automatic logic [TIME_W-1:0] probe_time();
        logic [TIME_W-1:0] base;
        base = dedup.kept_time;
        case ($urandom_range(0, 5))
            0:       return base + dedup.age_floor;
            1:       return base + dedup.age_floor - 32'd1;
            2:       return base + dedup.age_floor + 32'd1;
            3:       return base + 32'($urandom_range(0, 2000));
            4:       return base - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge that took the word.
    task automatic send_word(input logic op, input logic [TIME_W-1:0] t,
                             input logic [ID_W-1:0] id, input logic [COUNT_W-1:0] cnt,
                             input logic last);
        int   gap;
        logic ready_seen;
        if (!quiet && !src_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (!quiet && $urandom_range(0, 40) == 0)
            src_calm = !src_calm;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cnt, id, t};
        s_tuser  <= op;
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        dedup.absorb_word(op, t, id, cnt, last);
        words_sent++;
    endtask

    // Only the final word's op and time matter; earlier words get random ones.
    task automatic send_scan(input logic op, input logic [TIME_W-1:0] t,
                             input id_list_t ids, input logic [COUNT_W-1:0] cnt);
        for (int k = 0; k < ids.size(); k++)
        begin
            if (k == ids.size() - 1)
                send_word(op, t, ids[k], cnt, 1'b1);
            else
                send_word(logic'($urandom_range(0, 1)), $urandom, ids[k], cnt, 1'b0);
        end
    endtask

    task automatic write_min_age(input logic [TIME_W-1:0] v);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
        dedup.age_floor = v;
    endtask

    // Wait for all owed replies, then idle before the next phase.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (dedup.owed_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_scan();
        id_list_t           ids;
        logic [ID_W-1:0]    tmp;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  t;
        int                 kind;
        int                 sc;
        int                 n;
        int                 pos;
        kind = $urandom_range(0, 99);
        sc   = dedup.kept_count;
        if (kind < 40)
        begin
            // well-formed record, ids partly reused from the stored set
            n = pick_size();
            for (int k = 0; k < n; k++)
                ids.push_back((sc > 0 && $urandom_range(0, 1) == 1) ?
                              dedup.kept_ids[$urandom_range(0, sc - 1)] : random_id());
            t = ($urandom_range(0, 3) == 0) ? $urandom :
                dedup.kept_time + 32'($urandom_range(0, 5000));
            send_scan(OP_RECORD, t, ids, COUNT_W'(n));
        end
        else if (kind < 80)
        begin
            // check against the stored set: repeat, shuffled, or slightly off
            if (sc == 0)
            begin
                n = pick_size();
                for (int k = 0; k < n; k++)
                    ids.push_back(random_id());
            end
            else
            begin
                for (int k = 0; k < sc; k++)
                    ids.push_back(dedup.kept_ids[k]);
                for (int k = sc - 1; k > 0; k--)
                begin
                    pos = $urandom_range(0, k);
                    tmp = ids[k];
                    ids[k] = ids[pos];
                    ids[pos] = tmp;
                end
                pos = $urandom_range(0, ids.size() - 1);
                case ($urandom_range(0, 6))
                    3:       ids[pos] = random_id();
                    4:       ids.insert(pos, random_id());
                    5:       if (ids.size() > 1) ids.delete(pos);
                    6:       ids[pos] = ids[$urandom_range(0, ids.size() - 1)];
                    default: ;
                endcase
            end
            send_scan(OP_CHECK, probe_time(), ids, COUNT_W'(ids.size()));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    send_word(logic'($urandom_range(0, 1)), $urandom, random_id(), '0,
                              logic'($urandom_range(0, 1)));
                end
                1:
                begin
                    // partial scan cut short by an empty word
                    n = $urandom_range(1, 5);
                    for (int k = 0; k < n; k++)
                        send_word(logic'($urandom_range(0, 1)), $urandom, random_id(),
                                  COUNT_W'(n + 1), 1'b0);
                    send_word(logic'($urandom_range(0, 1)), $urandom, random_id(), '0,
                              logic'($urandom_range(0, 1)));
                end
                2:
                begin
                    // count field unrelated to the word count
                    n = $urandom_range(1, SCAN_MAX);
                    for (int k = 0; k < n; k++)
                        ids.push_back(random_id());
                    send_scan(logic'($urandom_range(0, 1)), probe_time(), ids,
                              COUNT_W'($urandom_range(1, 31)));
                end
                default:
                begin
                    // oversized count field, past SCAN_MAX; word count random or equal to it
                    cnt = COUNT_W'($urandom_range(SCAN_MAX + 1, 31));
                    n = ($urandom_range(0, 1) == 1) ? int'(cnt) : $urandom_range(1, 20);
                    for (int k = 0; k < n; k++)
                        ids.push_back(random_id());
                    send_scan(logic'($urandom_range(0, 1)), probe_time(), ids, cnt);
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, threshold 1000 ms.
        write_min_age(32'd1000);
        send_scan(OP_CHECK, 32'd5, '{48'h0}, 5'd1);                 // nothing stored yet
        send_word(OP_CHECK, 32'd0, 48'h1234_5678_9ABC, 5'd0, 1'b1);  // empty check
        send_word(OP_RECORD, '1, '1, 5'd0, 1'b0);                    // empty record, no tlast
        send_scan(OP_RECORD, 32'hFFFF_FF00,
                  '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hA5A5_5A5A_C3C3}, 5'd3);
        // same set reordered, age wraps to 272 ms: repeat, not wanted
        send_scan(OP_CHECK, 32'h0000_0010,
                  '{48'hA5A5_5A5A_C3C3, 48'h0, 48'hFFFF_FFFF_FFFF}, 5'd3);
        // age exactly at the threshold
        send_scan(OP_CHECK, 32'hFFFF_FF00 + 32'd1000,
                  '{48'hFFFF_FFFF_FFFF, 48'hA5A5_5A5A_C3C3, 48'h0}, 5'd3);
        // duplicate hides a missing stored id
        send_scan(OP_CHECK, 32'hFFFF_FF00 + 32'd999,
                  '{48'h0, 48'h0, 48'hFFFF_FFFF_FFFF}, 5'd3);
        // count differs
        send_scan(OP_CHECK, 32'd20,
                  '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hA5A5_5A5A_C3C3, 48'h7}, 5'd4);
        // too few words for the count, then too many
        send_scan(OP_CHECK, 32'd20, '{48'h0, 48'hFFFF_FFFF_FFFF}, 5'd3);
        send_scan(OP_RECORD, 32'd30, '{48'h1, 48'h2, 48'h3}, 5'd2);
        // partial scan dropped by an empty record
        send_word(OP_RECORD, 32'd40, 48'h11, 5'd3, 1'b0);
        send_word(OP_CHECK, 32'd40, 48'h22, 5'd3, 1'b0);
        send_word(OP_RECORD, 32'd40, 48'h33, 5'd0, 1'b1);
        // count field past SCAN_MAX
        send_scan(OP_CHECK, 32'd50, '{48'hFFFF_FFFF_FFFF}, 5'd31);
        send_scan(OP_RECORD, 32'd60, '{48'h5555_AAAA_5555}, 5'd1);
        settle();

        // Random phases across threshold settings, extremes first.
        write_min_age(32'd0);
        while (words_sent < 600)
            random_scan();
        settle();

        write_min_age(32'hFFFF_FFFF);
        while (words_sent < 1000)
            random_scan();
        settle();

        write_min_age(32'($urandom_range(1, 5000)));
        while (words_sent < 1400)
            random_scan();
        settle();

        write_min_age($urandom);
        while (words_sent < 1900)
        begin
            if (words_sent > 1650)
                quiet = 1'b1;
            random_scan();
        end
        settle();

        if (dedup.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
